### hdl/igsg_pkg.sv
// Shared constants, codes and types of the isometric grid segment generator.
package igsg_pkg;

   localparam int MAX_COLS = 1024;
   localparam int MAX_ROWS = 1024;

   localparam int COL_W  = $clog2(MAX_COLS + 1);
   localparam int ROW_W  = $clog2(MAX_ROWS);
   localparam int ADDR_W = $clog2(MAX_COLS);

   localparam int HEIGHT_W    = 16;
   localparam int COORD_W     = 25;
   localparam int ROW_WIDTH_W = 11;
   localparam int TWH_W       = 10;
   localparam int THH_W       = 10;
   localparam int DEPTH_W     = 9;
   localparam int CSR_DATA_W  = 11;
   localparam int CSR_INDEX_W = 2;

   localparam int SUM_W   = ((COL_W > ROW_W) ? COL_W : ROW_W) + 1;
   localparam int DIFF_W  = SUM_W + 1;
   localparam int PX_W    = DIFF_W + TWH_W + 1;
   localparam int PY_W    = SUM_W + THH_W - 1;
   localparam int PRODH_W = HEIGHT_W + DEPTH_W;

   localparam logic [ROW_WIDTH_W-1:0] ROW_WIDTH_RST = ROW_WIDTH_W'(1);
   localparam logic [TWH_W-1:0]       TWH_RST       = TWH_W'(10);
   localparam logic [THH_W-1:0]       THH_RST       = THH_W'(10);
   localparam logic [DEPTH_W-1:0]     DEPTH_RST     = DEPTH_W'(1);

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_ROW_WIDTH        = 2'd0,
      CSR_X_STEP           = 2'd1,
      CSR_TILE_HEIGHT_HALF = 2'd2,
      CSR_DEPTH_SCALE      = 2'd3
   } csr_index_type;

   typedef enum logic {
      SEG_LEFT = 1'b0,
      SEG_UP   = 1'b1
   } seg_kind_type;

   // Products of one grid point, handed to the segment stage
   typedef struct packed {
      logic signed [PX_W-1:0]    px;
      logic        [PY_W-1:0]    py;
      logic signed [PRODH_W-1:0] hd;
      logic signed [PRODH_W-1:0] pd;
      logic signed [PRODH_W-1:0] ud;
      logic                      has_left;
      logic                      has_up;
   } proj_type;

endpackage

### hdl/igsg_req_if.sv
// Sample channel: valid/ready plus height and frame start flag.
interface igsg_req_if import igsg_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic signed [HEIGHT_W-1:0] height;
   logic                       frame_start;

   modport source (output valid, output height, output frame_start, input ready);
   modport sink   (input valid, input height, input frame_start, output ready);
endinterface

### hdl/igsg_rsp_if.sv
// Segment channel: valid/ready plus the two screen points and flags.
interface igsg_rsp_if import igsg_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic signed [COORD_W-1:0] start_x;
   logic signed [COORD_W-1:0] start_y;
   logic signed [COORD_W-1:0] end_x;
   logic signed [COORD_W-1:0] end_y;
   logic                      segment_kind;
   logic                      last_of_item;

   modport source (output valid, output start_x, output start_y, output end_x,
                   output end_y, output segment_kind, output last_of_item,
                   input ready);
   modport sink   (input valid, input start_x, input start_y, input end_x,
                   input end_y, input segment_kind, input last_of_item,
                   output ready);
endinterface

### hdl/igsg_emit.sv
// Segment stage: holds one point's products and issues its segments into the output register.
module igsg_emit import igsg_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             item_valid,
   output logic             item_ready,
   input  proj_type         item,
   input  logic [TWH_W-1:0] x_step,
   input  logic [THH_W-2:0] tile_height_step,
   igsg_rsp_if.source       rsp_if
);

   logic                      s2_valid_ff, s2_valid_in;
   logic                      phase_ff, phase_in;
   proj_type                  s2_item_ff;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic signed [COORD_W-1:0] sx_ff, sy_ff, ex_ff, ey_ff;
   logic                      kind_ff, last_ff;

   logic                      out_free, emit_left, emit_up, load, s2_done;
   logic signed [COORD_W-1:0] sx, sy, base_y, ex, ey;

   assign out_free  = !rsp_valid_ff || rsp_if.ready;
   assign emit_left = s2_valid_ff && s2_item_ff.has_left && !phase_ff;
   assign emit_up   = s2_valid_ff && s2_item_ff.has_up
                      && (phase_ff || !s2_item_ff.has_left);
   assign load      = out_free && (emit_left || emit_up);
   // done when nothing to emit, or the final segment goes out now
   assign s2_done   = s2_valid_ff && ((!emit_left && !emit_up)
                      || (out_free && !(emit_left && s2_item_ff.has_up)));
   assign item_ready = !s2_valid_ff || s2_done;

   always_comb begin
      sx     = COORD_W'(s2_item_ff.px);
      sy     = $signed(COORD_W'(s2_item_ff.py)) - COORD_W'(s2_item_ff.hd);
      base_y = $signed(COORD_W'(s2_item_ff.py))
               - $signed(COORD_W'(tile_height_step));
      if (emit_left) begin
         ex = sx - $signed(COORD_W'(x_step));
         ey = base_y - COORD_W'(s2_item_ff.pd);
      end else begin
         ex = sx + $signed(COORD_W'(x_step));
         ey = base_y - COORD_W'(s2_item_ff.ud);
      end
   end

   always_comb begin
      s2_valid_in = s2_valid_ff;
      phase_in    = phase_ff;
      if (item_ready) begin
         s2_valid_in = item_valid;
         phase_in    = 1'b0;
      end else if (load) begin
         phase_in = 1'b1;
      end
      rsp_valid_in = load || (rsp_valid_ff && !rsp_if.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff  <= 1'b0;
         phase_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff  <= s2_valid_in;
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (item_ready) begin
         s2_item_ff <= item;
      end
      if (load) begin
         sx_ff   <= sx;
         sy_ff   <= sy;
         ex_ff   <= ex;
         ey_ff   <= ey;
         kind_ff <= emit_left ? SEG_LEFT : SEG_UP;
         last_ff <= emit_left ? !s2_item_ff.has_up : 1'b1;
      end
   end

   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.start_x      = sx_ff;
   assign rsp_if.start_y      = sy_ff;
   assign rsp_if.end_x        = ex_ff;
   assign rsp_if.end_y        = ey_ff;
   assign rsp_if.segment_kind = kind_ff;
   assign rsp_if.last_of_item = last_ff;

endmodule

### hdl/isometric_grid_segment_generator.sv
// Isometric grid segment generator: top level with position counters and line buffer.
//
// Takes one height sample per transfer in raster order and gives the wireframe
// segments of each grid point: first the one to its left neighbour (column > 1),
// then the one to its upper neighbour (row > 0). A sample is taken in every
// cycle while the segment side keeps up; a point that makes two segments holds
// the segment channel for both in turn, and back-pressure on it stalls the
// sample channel, so the pace is set by the single segment register on the
// result side. A segment reaches the result port through three registers:
// sample register with the line buffer read, product register, output
// register. The line buffer is a MAX_COLS x 16 RAM, one write and one
// registered read per sample; it is not cleared after reset, so an
// upper-neighbour read of an entry never written (only possible when
// row_width grows inside a frame) returns stale data.
// Configuration writes take effect at once and belong to idle periods.
module isometric_grid_segment_generator import igsg_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   igsg_req_if.sink               req_if,
   igsg_rsp_if.source             rsp_if,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   // control registers
   logic [ROW_WIDTH_W-1:0]    row_width_ff;
   logic [TWH_W-1:0]          twh_ff;
   logic [THH_W-1:0]          thh_ff;
   logic signed [DEPTH_W-1:0] depth_ff;

   // grid position and left-neighbour height
   logic [COL_W-1:0]           column_pos_ff, column_pos_in;
   logic [ROW_W-1:0]           row_pos_ff, row_pos_in;
   logic signed [HEIGHT_W-1:0] prev_height_ff;

   // previous row of heights
   logic signed [HEIGHT_W-1:0] line_mem [MAX_COLS];

   // sample register
   logic                       s1_valid_ff, s1_valid_in;
   logic [COL_W-1:0]           s1_col_ff;
   logic [ROW_W-1:0]           s1_row_ff;
   logic signed [HEIGHT_W-1:0] s1_height_ff, s1_prev_ff, up_height_ff;

   logic                       accept, emit_ready, wrap;
   logic [COL_W-1:0]           col_cur, width_eff;
   logic [ROW_W-1:0]           row_cur;
   logic [ADDR_W-1:0]          idx;
   logic [SUM_W-1:0]           pos_sum;
   logic signed [DIFF_W-1:0]   pos_diff;
   proj_type                   proj;

   assign accept        = req_if.valid && req_if.ready;
   assign req_if.ready  = !s1_valid_ff || emit_ready;

   // Position of this sample; frame start restarts at column 1, row 0
   always_comb begin
      col_cur = req_if.frame_start ? COL_W'(1) : column_pos_ff;
      row_cur = req_if.frame_start ? '0 : row_pos_ff;
      if (row_width_ff == '0) begin
         width_eff = COL_W'(1);
      end else if (int'(row_width_ff) > MAX_COLS) begin
         width_eff = COL_W'(MAX_COLS);
      end else begin
         width_eff = COL_W'(row_width_ff);
      end
      // a width cut below the current column still ends the row here
      wrap          = col_cur >= width_eff;
      column_pos_in = wrap ? COL_W'(1) : col_cur + COL_W'(1);
      if (wrap && row_cur != ROW_W'(MAX_ROWS - 1)) begin
         row_pos_in = row_cur + ROW_W'(1);
      end else begin
         row_pos_in = row_cur;
      end
      idx = ADDR_W'(col_cur - COL_W'(1));
      s1_valid_in = accept || (s1_valid_ff && !emit_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_width_ff   <= ROW_WIDTH_RST;
         twh_ff         <= TWH_RST;
         thh_ff         <= THH_RST;
         depth_ff       <= DEPTH_RST;
         column_pos_ff  <= COL_W'(1);
         row_pos_ff     <= '0;
         prev_height_ff <= '0;
         s1_valid_ff    <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index_type'(csr_index))
               CSR_ROW_WIDTH:        row_width_ff <= ROW_WIDTH_W'(csr_wdata);
               CSR_X_STEP:           twh_ff       <= TWH_W'(csr_wdata);
               CSR_TILE_HEIGHT_HALF: thh_ff       <= THH_W'(csr_wdata);
               CSR_DEPTH_SCALE:      depth_ff     <= DEPTH_W'(csr_wdata);
               default: ;
            endcase
         end
         if (accept) begin
            column_pos_ff  <= column_pos_in;
            row_pos_ff     <= row_pos_in;
            prev_height_ff <= req_if.height;
         end
         s1_valid_ff <= s1_valid_in;
      end
   end

   // Line buffer: old entry read out before the same transfer overwrites it
   always_ff @(posedge clock) begin
      if (accept) begin
         line_mem[idx] <= req_if.height;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         up_height_ff <= line_mem[idx];
         s1_col_ff    <= col_cur;
         s1_row_ff    <= row_cur;
         s1_height_ff <= req_if.height;
         s1_prev_ff   <= prev_height_ff;
      end
   end

   // Projection products; neighbour points differ by one step in x and y
   always_comb begin
      pos_sum      = SUM_W'(s1_col_ff) + SUM_W'(s1_row_ff);
      pos_diff     = $signed(DIFF_W'(s1_col_ff)) - $signed(DIFF_W'(s1_row_ff));
      proj.px      = PX_W'(pos_diff) * PX_W'($signed({1'b0, twh_ff}));
      proj.py      = PY_W'(pos_sum) * PY_W'(thh_ff[THH_W-1:1]);
      proj.hd      = PRODH_W'(s1_height_ff) * PRODH_W'(depth_ff);
      proj.pd      = PRODH_W'(s1_prev_ff) * PRODH_W'(depth_ff);
      proj.ud      = PRODH_W'(up_height_ff) * PRODH_W'(depth_ff);
      proj.has_left = s1_col_ff > COL_W'(1);
      proj.has_up   = s1_row_ff != '0;
   end

   igsg_emit u_emit (
      .clock            (clock),
      .reset            (reset),
      .item_valid       (s1_valid_ff),
      .item_ready       (emit_ready),
      .item             (proj),
      .x_step           (twh_ff),
      .tile_height_step (thh_ff[THH_W-1:1]),
      .rsp_if           (rsp_if)
   );

   // frame start lands at column 1 of row 0, so the next position is fixed
   a_frame_restart: assert property (@(posedge clock) disable iff (reset)
      accept && req_if.frame_start |=>
         (column_pos_ff == COL_W'(2) && row_pos_ff == '0)
         || (column_pos_ff == COL_W'(1) && row_pos_ff == ROW_W'(1)))
      else $error("position after frame start is wrong");

   // a left segment that is not last is followed at once by the upper one
   a_pair_order: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && rsp_if.ready && rsp_if.segment_kind == SEG_LEFT
         && !rsp_if.last_of_item |=> rsp_if.valid && rsp_if.segment_kind == SEG_UP)
      else $error("upper segment missing after left segment");

   // the upper segment always closes its sample
   a_up_last: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && rsp_if.segment_kind == SEG_UP |-> rsp_if.last_of_item)
      else $error("upper segment not marked last");

   // an empty sample register never blocks the sample channel
   a_ready_free: assert property (@(posedge clock) disable iff (reset)
      !s1_valid_ff |-> req_if.ready)
      else $error("sample channel stalled with empty sample register");

endmodule

### dv/isometric_grid_segment_generator_test.sv
// Self-checking testbench of the isometric grid segment generator.
module isometric_grid_segment_generator_test;
   timeunit 1ns;
   timeprecision 1ps;
   import igsg_pkg::*;

   // Cycles allowed after the last expected segment: three-stage pipe plus margin
   localparam int SETTLE_CYCLES = 10;

   // One expected segment, field for field as it leaves the block
   typedef struct {
      logic signed [COORD_W-1:0] start_x;
      logic signed [COORD_W-1:0] start_y;
      logic signed [COORD_W-1:0] end_x;
      logic signed [COORD_W-1:0] end_y;
      seg_kind_type              kind;
      logic                      last_of_item;
   } segment_type;

   logic clock = 1'b0;
   logic reset;

   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   igsg_req_if req_bus ();
   igsg_rsp_if rsp_bus ();

   isometric_grid_segment_generator DUT (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_bus),
      .rsp_if    (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #5ns clock = ~clock;

   // Idling knobs, percent of cycles
   int sender_idle_pct = 0;
   int stall_pct       = 0;
   int mismatches      = 0;

   // Predictor's copy of the registers
   logic [ROW_WIDTH_W-1:0]   cfg_row_width = ROW_WIDTH_RST;
   logic [TWH_W-1:0]         cfg_tile_w    = TWH_RST;
   logic [THH_W-1:0]         cfg_tile_h    = THH_RST;
   logic signed [DEPTH_W-1:0] cfg_depth    = DEPTH_RST;

   // Predictor's copy of the grid walk and the line buffer
   int                         grid_col    = 1;
   int                         grid_row    = 0;
   logic signed [HEIGHT_W-1:0] left_height = '0;
   logic signed [HEIGHT_W-1:0] upper_heights [MAX_COLS];
   bit                         upper_written [MAX_COLS];

   segment_type pending_segments [$];

   // ------------------------------------------------------------------
   // Predictor: projects one accepted sample and queues its segments
   // ------------------------------------------------------------------
   function automatic void project_sample(input logic signed [HEIGHT_W-1:0] h,
                                          input logic fs);
      int          width;
      int          slot;
      longint      tw;
      longint      half_h;
      longint      ds;
      longint      sx;
      longint      sy;
      bit          has_left;
      bit          has_up;
      segment_type seg;
      // out-of-range widths: 0 behaves as 1, anything past the buffer as full
      width = cfg_row_width;
      if (width < 1) width = 1;
      if (width > MAX_COLS) width = MAX_COLS;
      if (fs) begin
         grid_col = 1;
         grid_row = 0;
      end
      slot   = (grid_col - 1) % MAX_COLS;
      tw     = cfg_tile_w;
      half_h = cfg_tile_h >> 1;   // truncating halve
      ds     = cfg_depth;
      sx     = (grid_col - grid_row) * tw;
      sy     = (grid_col + grid_row) * half_h - longint'(h) * ds;
      has_left = grid_col > 1;
      has_up   = grid_row > 0;
      seg.start_x = COORD_W'(sx);
      seg.start_y = COORD_W'(sy);
      if (has_left) begin
         seg.kind         = SEG_LEFT;
         seg.end_x        = COORD_W'((grid_col - 1 - grid_row) * tw);
         seg.end_y        = COORD_W'((grid_col - 1 + grid_row) * half_h
                                     - longint'(left_height) * ds);
         seg.last_of_item = !has_up;
         pending_segments.push_back(seg);
      end
      if (has_up) begin
         seg.kind         = SEG_UP;
         seg.end_x        = COORD_W'((grid_col - grid_row + 1) * tw);
         seg.end_y        = COORD_W'((grid_col + grid_row - 1) * half_h
                                     - longint'(upper_heights[slot]) * ds);
         seg.last_of_item = 1'b1;
         pending_segments.push_back(seg);
      end
      upper_heights[slot] = h;
      upper_written[slot] = 1'b1;
      left_height = h;
      // a sample past a shrunken width still lands at its column, then wraps
      grid_col++;
      if (grid_col > width) begin
         grid_col = 1;
         if (grid_row < MAX_ROWS - 1) grid_row++;
      end
   endfunction

   // ------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------

   // One sample transfer; returns at the falling edge after acceptance with
   // valid still high, so a following sample goes out back to back.
   task automatic send_sample(input logic signed [HEIGHT_W-1:0] h, input logic fs);
      logic restart;
      restart = fs;
      // never let the block read a buffer slot that was never filled:
      // open a new frame instead
      if (!restart && grid_row != 0 && !upper_written[(grid_col - 1) % MAX_COLS])
         restart = 1'b1;
      while ($urandom_range(99) < sender_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid       <= 1'b1;
      req_bus.height      <= h;
      req_bus.frame_start <= restart;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      project_sample(h, restart);
      @(negedge clock);
   endtask

   // Hold the sender off until every expected segment is out, then let the
   // pipe settle (a first point leaves no segment to wait for).
   task automatic wait_for_segments();
      req_bus.valid <= 1'b0;
      while (pending_segments.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Writes all four registers once the block is idle
   task automatic program_registers(input int width, input int twh, input int thh,
                                    input int ds);
      logic [DEPTH_W-1:0] depth_bits;
      wait_for_segments();
      depth_bits = DEPTH_W'(ds);
      csr_we    <= 1'b1;
      csr_index <= CSR_ROW_WIDTH;
      csr_wdata <= CSR_DATA_W'(width);
      @(negedge clock);
      csr_index <= CSR_X_STEP;
      csr_wdata <= CSR_DATA_W'(twh);
      @(negedge clock);
      csr_index <= CSR_TILE_HEIGHT_HALF;
      csr_wdata <= CSR_DATA_W'(thh);
      @(negedge clock);
      csr_index <= CSR_DEPTH_SCALE;
      csr_wdata <= CSR_DATA_W'(depth_bits);
      @(negedge clock);
      csr_we <= 1'b0;
      cfg_row_width = ROW_WIDTH_W'(width);
      cfg_tile_w    = TWH_W'(twh);
      cfg_tile_h    = THH_W'(thh);
      cfg_depth     = depth_bits;
   endtask

   // Heights lean on the extremes now and then
   function automatic logic signed [HEIGHT_W-1:0] pick_height();
      case ($urandom_range(7))
         0:       return 16'sh8000;
         1:       return 16'sh7fff;
         2:       return '0;
         default: return HEIGHT_W'($urandom);
      endcase
   endfunction

   task automatic random_settings();
      int width;
      int twh;
      int thh;
      int ds;
      case ($urandom_range(9))
         0:       width = 0;
         1:       width = 1;
         2:       width = 2;
         3:       width = MAX_COLS;
         4:       width = 2047;
         default: width = $urandom_range(3, 12);
      endcase
      case ($urandom_range(3))
         0:       twh = 0;
         1:       twh = 1023;
         default: twh = $urandom_range(1023);
      endcase
      case ($urandom_range(4))
         0:       thh = 0;
         1:       thh = 1;
         2:       thh = 1023;
         default: thh = $urandom_range(1023);
      endcase
      case ($urandom_range(5))
         0:       ds = -255;
         1:       ds = 255;
         2:       ds = 0;
         default: ds = int'($urandom_range(510)) - 255;
      endcase
      program_registers(width, twh, thh, ds);
   endtask

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // Reset values: width 1, so every sample is a row of its own
   task automatic test_reset_defaults();
      send_sample(16'sh7fff, 1'b0);
      send_sample(16'sh8000, 1'b0);
      send_sample(16'sh0000, 1'b0);
      send_sample(16'shffff, 1'b0);
   endtask

   // Extreme steps and heights, both segment kinds, a frame restart mid-row
   task automatic test_extremes_and_restart();
      program_registers(3, 1023, 1023, -255);
      send_sample(16'sh7fff, 1'b1);
      send_sample(16'sh8000, 1'b0);
      send_sample(16'sh0000, 1'b0);
      send_sample(16'shffff, 1'b0);
      send_sample(16'sh7fff, 1'b0);
      send_sample(16'sh8000, 1'b0);
      send_sample(16'sh3039, 1'b0);
      send_sample(16'sh8000, 1'b1);
      // zero horizontal step, odd height that halves to zero
      program_registers(2, 0, 1, 255);
      send_sample(16'sh8000, 1'b1);
      send_sample(16'sh7fff, 1'b0);
      send_sample(16'sh8000, 1'b0);
      send_sample(16'sh7fff, 1'b0);
      send_sample(16'sh5555, 1'b0);
      send_sample(16'shaaaa, 1'b0);
   endtask

   // Width 0 behaves as 1; an oversize width behaves as the full buffer
   task automatic test_row_width_clamp();
      program_registers(0, 7, 9, 3);
      repeat (3) send_sample(pick_height(), 1'b0);
      program_registers(2047, 1023, 1023, 255);
      send_sample(pick_height(), 1'b1);
      repeat (MAX_COLS + 2) send_sample(pick_height(), 1'b0);
   endtask

   // Width cut below the current column: that sample stays put, then wraps
   task automatic test_width_shrink_mid_row();
      program_registers(8, 5, 6, -7);
      send_sample(pick_height(), 1'b1);
      repeat (12) send_sample(pick_height(), 1'b0);
      program_registers(3, 5, 6, -7);
      repeat (7) send_sample(pick_height(), 1'b0);
   endtask

   // Row counter sticks at its top value while the buffer keeps going
   task automatic test_row_saturation();
      program_registers(1, 3, 4, 2);
      send_sample(pick_height(), 1'b1);
      repeat (MAX_ROWS + 6) send_sample(pick_height(), 1'b0);
   endtask

   // Raster streams under random settings; a few stray frame restarts
   task automatic test_random_phase(input int idle_pct, input int stall_in,
                                    input int n_items);
      logic fs;
      sender_idle_pct = idle_pct;
      stall_pct       = stall_in;
      for (int k = 0; k < n_items; k++) begin
         fs = ($urandom_range(49) == 0);
         if (k % 100 == 0) begin
            random_settings();
            fs = ($urandom_range(3) != 0);
         end
         // one hold-off mid-stream until the pipe has fully drained
         if (k == n_items / 2 + 25) wait_for_segments();
         send_sample(pick_height(), fs);
      end
   endtask

   // ------------------------------------------------------------------
   // Result side: random back-pressure and checking against the queue
   // ------------------------------------------------------------------
   always @(negedge clock) rsp_bus.ready <= ($urandom_range(99) >= stall_pct);

   task automatic report_segment(input string what, input segment_type want);
      mismatches++;
      if (mismatches <= 10) begin
         $display("%0t %s: expected (%0d,%0d)-(%0d,%0d) kind %0d last %0d,",
                  $time, what, want.start_x, want.start_y, want.end_x, want.end_y,
                  want.kind, want.last_of_item);
         $display("   got (%0d,%0d)-(%0d,%0d) kind %0d last %0d",
                  rsp_bus.start_x, rsp_bus.start_y, rsp_bus.end_x, rsp_bus.end_y,
                  rsp_bus.segment_kind, rsp_bus.last_of_item);
      end
   endtask

   always @(posedge clock) begin
      segment_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_segments.size() == 0) begin
            report_segment("segment with none expected", want);
         end else begin
            want = pending_segments.pop_front();
            if (rsp_bus.start_x !== want.start_x || rsp_bus.start_y !== want.start_y ||
                rsp_bus.end_x !== want.end_x || rsp_bus.end_y !== want.end_y ||
                rsp_bus.segment_kind !== want.kind ||
                rsp_bus.last_of_item !== want.last_of_item)
               report_segment("segment mismatch", want);
         end
      end
   end

   // ------------------------------------------------------------------
   // Sequence
   // ------------------------------------------------------------------
   initial begin
      reset               = 1'b1;
      req_bus.valid       = 1'b0;
      req_bus.height      = '0;
      req_bus.frame_start = 1'b0;
      csr_we              = 1'b0;
      csr_index           = CSR_ROW_WIDTH;
      csr_wdata           = '0;
      repeat (10) @(negedge clock);
      reset <= 1'b0;

      test_reset_defaults();
      test_extremes_and_restart();
      test_row_width_clamp();
      test_width_shrink_mid_row();
      test_row_saturation();
      test_random_phase(0, 0, 200);
      test_random_phase(73, 0, 200);
      test_random_phase(0, 73, 200);
      test_random_phase(16, 16, 200);

      wait_for_segments();
      if (mismatches == 0)
         $display("isometric_grid_segment_generator_test OK");
      else
         $display("isometric_grid_segment_generator_test NOT OK");
      $finish;
   end

   // Watchdog, far beyond the slowest legal run
   initial begin
      #5ms;
      $display("isometric_grid_segment_generator_test NOT OK");
      $finish;
   end

endmodule

### sim.f
hdl/igsg_pkg.sv
hdl/igsg_req_if.sv
hdl/igsg_rsp_if.sv
hdl/igsg_emit.sv
hdl/isometric_grid_segment_generator.sv
dv/isometric_grid_segment_generator_test.sv
